[src/largest_zero_rectangle_finder_macros.svh]
// Assertion macros shared by the largest zero rectangle finder RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LARGEST_ZERO_RECTANGLE_FINDER_MACROS_SVH
`define LARGEST_ZERO_RECTANGLE_FINDER_MACROS_SVH

// Same-cycle implication.
`define LZR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LZR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lzr_pkg.sv]
// Package of the largest zero rectangle finder: frame limits, register codes, field
// widths and the control structs between the top level and the walk unit. No dependencies.
`default_nettype none

package lzr_pkg;

  // Largest frame the run memories hold; the result fields are sized for it.
  localparam int unsigned MAX_COLS = 256;
  localparam int unsigned MAX_ROWS = 256;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned RX_W     = 8;
  localparam int unsigned RY_W     = 8;
  localparam int unsigned RW_W     = 9;
  localparam int unsigned RH_W     = 9;
  localparam int unsigned RAREA_W  = 17;

  typedef struct packed {
    logic [RX_W-1:0]    rect_x;
    logic [RY_W-1:0]    rect_y;
    logic [RW_W-1:0]    rect_width;
    logic [RH_W-1:0]    rect_height;
    logic [RAREA_W-1:0] rect_area;
  } rect_t;

  // Commands from the sequencer to the walk unit.
  typedef struct packed {
    logic wr_en;
    logic start;
    logic clear;
  } walk_cmd_t;

  typedef struct packed {
    logic busy;
  } walk_stat_t;

endpackage

`default_nettype wire

[src/lzr_if.sv]
// Handshake interfaces of the largest zero rectangle finder: the pixel input
// channel and the rectangle result channel. Depends on lzr_pkg.
`default_nettype none

interface lzr_pixel_if;
  import lzr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface lzr_rect_if;
  import lzr_pkg::*;

  logic               valid;
  logic               ready;
  logic [RX_W-1:0]    rect_x;
  logic [RY_W-1:0]    rect_y;
  logic [RW_W-1:0]    rect_width;
  logic [RH_W-1:0]    rect_height;
  logic [RAREA_W-1:0] rect_area;

  modport source (output valid, output rect_x, output rect_y, output rect_width,
                  output rect_height, output rect_area, input ready);
  modport sink   (input valid, input rect_x, input rect_y, input rect_width,
                  input rect_height, input rect_area, output ready);
endinterface

`default_nettype wire

[src/lzr_walk.sv]
// Left-run memory and column walk unit: stores the left run of every pixel and
// walks up a column to track the best rectangle. Depends on lzr_pkg and the macros.
`default_nettype none

module lzr_walk (
  input  wire                                                  clk_i,
  input  wire                                                  rst_ni,
  input  lzr_pkg::walk_cmd_t                                   cmd_i,
  output lzr_pkg::walk_stat_t                                  stat_o,
  input  wire [$clog2(lzr_pkg::MAX_COLS*lzr_pkg::MAX_ROWS)-1:0] wr_addr_i,
  input  wire [$clog2(lzr_pkg::MAX_COLS+1)-1:0]                wr_left_i,
  input  wire [$clog2(lzr_pkg::MAX_COLS)-1:0]                  col_i,
  input  wire [$clog2(lzr_pkg::MAX_ROWS)-1:0]                  row_i,
  input  wire [$clog2(lzr_pkg::MAX_ROWS+1)-1:0]                up_len_i,
  output logic [$clog2(lzr_pkg::MAX_COLS)-1:0]                 best_x_o,
  output logic [$clog2(lzr_pkg::MAX_ROWS)-1:0]                 best_y_o,
  output logic [$clog2(lzr_pkg::MAX_COLS+1)-1:0]               best_w_o,
  output logic [$clog2(lzr_pkg::MAX_ROWS+1)-1:0]               best_h_o,
  output logic [$clog2(lzr_pkg::MAX_COLS*lzr_pkg::MAX_ROWS+1)-1:0] best_area_o
);
  import lzr_pkg::*;

  `include "largest_zero_rectangle_finder_macros.svh"

  localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(MAX_COLS);
  localparam int unsigned RW     = $clog2(MAX_ROWS);
  localparam int unsigned LW     = $clog2(MAX_COLS + 1);
  localparam int unsigned UW     = $clog2(MAX_ROWS + 1);
  localparam int unsigned AREA_W = $clog2(DEPTH + 1);
  localparam int unsigned PW     = UW + LW;

  logic [LW-1:0] left_mem [DEPTH];

  // Walk issue stage.
  logic [UW-1:0]     cnt_q;
  logic [RW-1:0]     h_q;
  logic [AW-1:0]     addr_q;
  logic [CW-1:0]     col_q;
  logic [RW-1:0]     row_q;
  // Read data stage, running minimum, product stage, compare stage.
  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [RW-1:0]     s1_h_q, s2_h_q, s3_h_q;
  logic [LW-1:0]     rdata_q;
  logic [LW-1:0]     minw_q;
  logic [LW-1:0]     s3_minw_q;
  logic [AREA_W-1:0] area_q;
  logic [PW-1:0]     prod;
  logic              issue;

  logic [CW-1:0]     best_x_q;
  logic [RW-1:0]     best_y_q;
  logic [LW-1:0]     best_w_q;
  logic [UW-1:0]     best_h_q;
  logic [AREA_W-1:0] best_area_q;

  assign issue       = (cnt_q != '0);
  assign stat_o.busy = issue || s1_v_q || s2_v_q || s3_v_q;
  assign prod        = (PW'(s2_h_q) + PW'(1)) * PW'(minw_q);

  // Writes only happen while the walk is idle, so reads never see a write in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      left_mem[wr_addr_i] <= wr_left_i;
    end
    rdata_q <= left_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      h_q    <= '0;
      addr_q <= wr_addr_i;
      col_q  <= col_i;
      row_q  <= row_i;
      minw_q <= wr_left_i;
    end else begin
      if (issue) begin
        h_q    <= h_q + RW'(1);
        addr_q <= addr_q - AW'(MAX_COLS);
      end
      if (s1_v_q && (rdata_q < minw_q)) begin
        minw_q <= rdata_q;
      end
    end
    s1_h_q    <= h_q;
    s2_h_q    <= s1_h_q;
    s3_h_q    <= s2_h_q;
    area_q    <= AREA_W'(prod);
    s3_minw_q <= minw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_w_q    <= '0;
      best_h_q    <= '0;
      best_area_q <= '0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= up_len_i;
      end else if (issue) begin
        cnt_q <= cnt_q - UW'(1);
      end
      s1_v_q <= issue && !cmd_i.start;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (cmd_i.clear) begin
        best_x_q    <= '0;
        best_y_q    <= '0;
        best_w_q    <= '0;
        best_h_q    <= '0;
        best_area_q <= '0;
      end else if (s3_v_q && (area_q > best_area_q)) begin
        best_area_q <= area_q;
        best_x_q    <= CW'(LW'(col_q) + LW'(1) - s3_minw_q);
        best_y_q    <= row_q - s3_h_q;
        best_w_q    <= s3_minw_q;
        best_h_q    <= UW'(s3_h_q) + UW'(1);
      end
    end
  end

  assign best_x_o    = best_x_q;
  assign best_y_o    = best_y_q;
  assign best_w_o    = best_w_q;
  assign best_h_o    = best_h_q;
  assign best_area_o = best_area_q;

  `LZR_ASSERT_NXT(a_start_busy, cmd_i.start && (up_len_i != '0), stat_o.busy,
                  "walk did not start after a start command with a nonzero run")
  `LZR_ASSERT_IMP(a_no_write_busy, cmd_i.wr_en, !stat_o.busy,
                  "left-run memory written while the walk is reading it")
  `LZR_ASSERT_NXT(a_best_grows, !cmd_i.clear, best_area_q >= $past(best_area_q),
                  "best area shrank without a clear")

endmodule

`default_nettype wire

[src/largest_zero_rectangle_finder.sv]
// Each pixel is taken only in the idle state and runs through run computation, the
// column walk and the position step before the next pixel is taken; a zero pixel's
// walk makes one left-run memory read per row of its upward run of zeros. The result
// of a frame waits in the output register until transferred.
// Reset: control, positions and best rectangle clear, both sizes go to 256;
// the run memories keep no reset and need no clearing pass.
`default_nettype none

module largest_zero_rectangle_finder (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  lzr_pixel_if.sink                          pixel_i,
  lzr_rect_if.source                         rect_o,
  input  wire                                cfg_we_i,
  input  wire [lzr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [lzr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import lzr_pkg::*;

  `include "largest_zero_rectangle_finder_macros.svh"

  localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(MAX_COLS);
  localparam int unsigned RW     = $clog2(MAX_ROWS);
  localparam int unsigned LW     = $clog2(MAX_COLS + 1);
  localparam int unsigned UW     = $clog2(MAX_ROWS + 1);
  localparam int unsigned AREA_W = $clog2(DEPTH + 1);

  // Sequencer states: wait for a pixel, compute runs, walk the column, step position or emit.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;
  logic [CW-1:0]         col_q;
  logic [RW-1:0]         row_q;
  logic [AW-1:0]         row_base_q;
  logic [LW-1:0]         prev_left_q;
  logic                  px_zero_q;
  logic                  out_valid_q;
  rect_t                 rect_q;

  // The upward run of the latest pixel of each column.
  logic [UW-1:0]         up_mem [MAX_COLS];
  logic [UW-1:0]         up_rdata_q;

  logic [CW-1:0]         last_col;
  logic [RW-1:0]         last_row;
  logic                  accept, cfg_hit, advance, emit, last_pix, slot_free;
  logic [UW-1:0]         up_run;
  logic [LW-1:0]         left_run;
  walk_cmd_t             walk_cmd;
  walk_stat_t            walk_stat;

  logic [CW-1:0]         best_x;
  logic [RW-1:0]         best_y;
  logic [LW-1:0]         best_w;
  logic [UW-1:0]         best_h;
  logic [AREA_W-1:0]     best_area;

  // A size of zero acts as one, and a size past the memory saturates to it.
  always_comb begin
    if (frame_width_q == '0) begin
      last_col = '0;
    end else if (32'(frame_width_q) > 32'(MAX_COLS)) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(frame_width_q - CFG_DATA_W'(1));
    end
    if (frame_height_q == '0) begin
      last_row = '0;
    end else if (32'(frame_height_q) > 32'(MAX_ROWS)) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(frame_height_q - CFG_DATA_W'(1));
    end
  end

  assign accept    = pixel_i.valid && pixel_i.ready;
  assign cfg_hit   = cfg_we_i &&
                     ((cfg_index_i == REG_FRAME_WIDTH) || (cfg_index_i == REG_FRAME_HEIGHT));
  assign last_pix  = (col_q == last_col) && (row_q == last_row);
  assign slot_free = !out_valid_q || rect_o.ready;

  // Runs of zeros ending at this pixel. The left neighbor's run is the previous
  // pixel's, kept in a register; the run above comes from the column memory.
  always_comb begin
    if (px_zero_q) begin
      up_run   = UW'(1) + ((row_q != '0) ? up_rdata_q : UW'(0));
      left_run = LW'(1) + ((col_q != '0) ? prev_left_q : LW'(0));
    end else begin
      up_run   = '0;
      left_run = '0;
    end
  end

  always_comb begin
    state_d  = state_q;
    walk_cmd = '0;
    advance  = 1'b0;
    emit     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        walk_cmd.wr_en = 1'b1;
        walk_cmd.start = 1'b1;
        state_d        = S_WALK;
      end
      S_WALK: begin
        if (!walk_stat.busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_pix) begin
          advance = 1'b1;
          state_d = S_IDLE;
        end else if (slot_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    walk_cmd.clear = emit || cfg_hit;
  end

  // Column memory: read every cycle at the current column, written once per pixel.
  // The read for a pixel is taken at its transfer edge, after the previous write.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      up_mem[col_q] <= up_run;
    end
    up_rdata_q <= up_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_zero_q <= (pixel_i.pixel_value == '0);
    end
    if (state_q == S_CALC) begin
      prev_left_q <= left_run;
    end
    if (emit) begin
      rect_q.rect_x      <= RX_W'(best_x);
      rect_q.rect_y      <= RY_W'(best_y);
      rect_q.rect_width  <= RW_W'(best_w);
      rect_q.rect_height <= RH_W'(best_h);
      rect_q.rect_area   <= RAREA_W'(best_area);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      frame_width_q  <= DIM_RESET;
      frame_height_q <= DIM_RESET;
      col_q          <= '0;
      row_q          <= '0;
      row_base_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_index_i == REG_FRAME_WIDTH)) begin
        frame_width_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_FRAME_HEIGHT)) begin
        frame_height_q <= cfg_data_i;
      end
      // A write to a size register or the end of a frame starts a new frame.
      if (cfg_hit || emit) begin
        col_q      <= '0;
        row_q      <= '0;
        row_base_q <= '0;
      end else if (advance) begin
        if (col_q == last_col) begin
          col_q      <= '0;
          row_q      <= row_q + RW'(1);
          row_base_q <= row_base_q + AW'(MAX_COLS);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rect_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  lzr_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (walk_cmd),
    .stat_o      (walk_stat),
    .wr_addr_i   (row_base_q + AW'(col_q)),
    .wr_left_i   (left_run),
    .col_i       (col_q),
    .row_i       (row_q),
    .up_len_i    (up_run),
    .best_x_o    (best_x),
    .best_y_o    (best_y),
    .best_w_o    (best_w),
    .best_h_o    (best_h),
    .best_area_o (best_area)
  );

  assign pixel_i.ready      = (state_q == S_IDLE);
  assign rect_o.valid       = out_valid_q;
  assign rect_o.rect_x      = rect_q.rect_x;
  assign rect_o.rect_y      = rect_q.rect_y;
  assign rect_o.rect_width  = rect_q.rect_width;
  assign rect_o.rect_height = rect_q.rect_height;
  assign rect_o.rect_area   = rect_q.rect_area;

  `LZR_ASSERT_NXT(a_accept_calc, accept, state_q == S_CALC,
                  "pixel transfer did not start the run computation")
  `LZR_ASSERT_IMP(a_accept_walk_idle, accept, !walk_stat.busy,
                  "pixel transferred while a column walk is still running")
  `LZR_ASSERT_IMP(a_pos_in_frame, state_q == S_IDLE,
                  (col_q <= last_col) && (row_q <= last_row),
                  "raster position outside the frame")
  `LZR_ASSERT_IMP(a_emit_free, emit, !out_valid_q || rect_o.ready,
                  "result loaded over one not yet transferred")

endmodule

`default_nettype wire

[test/tb_largest_zero_rectangle_finder.sv]
// Testbench for largest_zero_rectangle_finder: streams binary frames through the pixel
// channel and checks each reported rectangle against a behavioral predictor.
// Depends on lzr_pkg, lzr_if.sv and the largest_zero_rectangle_finder RTL.
`default_nettype none

module tb_largest_zero_rectangle_finder;
  timeunit 1ns;
  timeprecision 1ps;

  import lzr_pkg::*;

  // The block decodes only the two size registers; these indexes must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Largest frame the block supports, in both directions.
  localparam int unsigned DIM_MAX = 256;

  // Cycles to let pass once the last result is in, before touching registers
  // or ending the run, long enough for the walk of any zero pixel to finish.
  localparam int unsigned SETTLE_CYCLES = 300;

  // Cycles the result side refuses transfers during the back-pressure phase.
  localparam int unsigned LONG_HOLD = 600;

  typedef enum {ROW_WRITE, ROW_FRAME, ROW_PARTIAL} row_op_e;
  typedef enum {FILL_FREE, FILL_BLOCKED, FILL_LAST_FREE, FILL_NOISE} fill_e;
  typedef enum {SINK_ALWAYS, SINK_HALF, SINK_SLOW} sink_mode_e;

  // One line of the directed table. For ROW_PARTIAL the data field holds the number
  // of pixels sent before the frame is abandoned.
  typedef struct {
    row_op_e               op;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    fill_e                 fill;
    bit                    typed;
    rect_t                 want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lzr_pixel_if pix_if ();
  lzr_rect_if  rect_if ();

  largest_zero_rectangle_finder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pix_if),
    .rect_o      (rect_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the run stores, the raster position, the best rectangle so
  // far and the two size registers as last written.
  // ---------------------------------------------------------------------------
  logic [8:0]            run_left [DIM_MAX*DIM_MAX];
  logic [8:0]            run_up [DIM_MAX];
  int unsigned           cur_row;
  int unsigned           cur_col;
  int unsigned           best_sz;
  rect_t                 best_rect;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  // Rectangles predicted for frames whose last pixel has been transferred.
  rect_t       pending_rects[$];
  int unsigned mismatch_count;

  // A directed row with a hand-written answer overrides the predicted rectangle.
  bit    typed_pending;
  rect_t typed_rect;

  // Set by the stimulus to ask the result side for one long hold-off.
  int unsigned hold_request;

  // Sender pacing: remaining transfers in the current burst, and whether gaps
  // between bursts are allowed at all.
  int unsigned burst_left;
  bit          gaps_on;

  stim_row_t directed_rows[$];

  // A size register of zero acts as one; anything above the maximum saturates.
  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic void restart_frame();
    cur_row   = 0;
    cur_col   = 0;
    best_sz   = 0;
    best_rect = '0;
  endfunction

  // Any write to a decoded register also throws away the frame in progress.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val;
      restart_frame();
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = val;
      restart_frame();
    end
  endfunction

  // Advances the predictor by one pixel. The pixel's left and upward zero runs are
  // stored, then the walk climbs the column through the upward run while keeping the
  // narrowest left run seen; each step is a candidate of height h+1. Only a strictly
  // larger area replaces the best, so on a tie the earlier rectangle stays.
  task automatic walk_pixel(input logic [PIX_W-1:0] px, output bit frame_done,
                            output rect_t found);
    int unsigned ew, eh, c, r, up, left, minw, wv, h, area;
    ew   = eff_dim(width_reg);
    eh   = eff_dim(height_reg);
    c    = cur_col;
    r    = cur_row;
    up   = 0;
    left = 0;
    if (px == 0) begin
      up   = 1 + ((r > 0) ? int'(run_up[c]) : 0);
      left = 1 + ((c > 0) ? int'(run_left[r*DIM_MAX + c - 1]) : 0);
    end
    run_up[c]              = 9'(up);
    run_left[r*DIM_MAX + c] = 9'(left);
    minw = left;
    for (h = 0; h < up && h <= r; h++) begin
      wv = run_left[(r - h)*DIM_MAX + c];
      if (wv < minw) minw = wv;
      area = (h + 1) * minw;
      if (area > best_sz) begin
        best_sz               = area;
        best_rect.rect_x      = 8'(c + 1 - minw);
        best_rect.rect_y      = 8'(r - h);
        best_rect.rect_width  = 9'(minw);
        best_rect.rect_height = 9'(h + 1);
      end
    end
    frame_done = 1'b0;
    found      = '0;
    if (c + 1 < ew) begin
      cur_col = c + 1;
    end else begin
      cur_col = 0;
      if (r + 1 < eh) begin
        cur_row = r + 1;
      end else begin
        frame_done      = 1'b1;
        found           = best_rect;
        found.rect_area = 17'(best_sz);
        restart_frame();
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge, where the values are
  // the ones settled since the previous falling edge. The pixel side is handled
  // first so that a prediction is queued before any result could be compared.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    bit    done;
    rect_t pred;
    rect_t want;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        walk_pixel(pix_if.pixel_value, done, pred);
        if (done) begin
          pending_rects.push_back(typed_pending ? typed_rect : pred);
          typed_pending = 1'b0;
        end
      end
      if (rect_if.valid && rect_if.ready) begin
        if (pending_rects.size() == 0) begin
          $error("rectangle transferred with no frame completed: x=%0d y=%0d w=%0d h=%0d",
                 rect_if.rect_x, rect_if.rect_y, rect_if.rect_width, rect_if.rect_height);
          mismatch_count++;
        end else begin
          want = pending_rects.pop_front();
          check_field("rect_x", want.rect_x, rect_if.rect_x);
          check_field("rect_y", want.rect_y, rect_if.rect_y);
          check_field("rect_width", want.rect_width, rect_if.rect_width);
          check_field("rect_height", want.rect_height, rect_if.rect_height);
          check_field("rect_area", want.rect_area, rect_if.rect_area);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side. Ready changes only at falling edges and follows a randomly redrawn
  // mode: always ready, ready half the time, or ready rarely. On request it refuses
  // every transfer for a long stretch, counted here.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned left_in_mode;
    int unsigned n;
    rect_if.ready = 1'b0;
    mode          = SINK_ALWAYS;
    left_in_mode  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        n            = hold_request;
        hold_request = 0;
        rect_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        if (left_in_mode == 0) begin
          mode         = sink_mode_e'($urandom_range(0, 2));
          left_in_mode = $urandom_range(30, 150);
        end
        left_in_mode--;
        case (mode)
          SINK_ALWAYS: begin
            rect_if.ready <= 1'b1;
          end
          SINK_HALF: begin
            rect_if.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            rect_if.ready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side and register port. Everything is driven at falling edges.
  // ---------------------------------------------------------------------------

  // Offers one pixel and returns at the falling edge after its transfer. Bursts of
  // random length are separated by random gaps unless gaps are switched off; within
  // a burst valid simply stays high from one pixel to the next.
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= v;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sends count pixels of a raster. A noise fill makes a pixel free with the given
  // percentage; blocked pixels get a random nonzero grey level.
  task automatic send_pixels(input fill_e fill, input int unsigned free_pct,
                             input int unsigned count);
    int unsigned k;
    logic [PIX_W-1:0] v;
    for (k = 0; k < count; k++) begin
      case (fill)
        FILL_FREE:      v = '0;
        FILL_BLOCKED:   v = PIX_W'($urandom_range(1, 255));
        FILL_LAST_FREE: v = (k == count - 1) ? '0 : PIX_W'($urandom_range(1, 255));
        default:        v = ($urandom_range(0, 99) < free_pct) ? '0
                                                                : PIX_W'($urandom_range(1, 255));
      endcase
      send_pixel(v);
    end
  endtask

  task automatic send_frame(input fill_e fill, input int unsigned free_pct,
                            output int unsigned count);
    count = eff_dim(width_reg) * eff_dim(height_reg);
    send_pixels(fill, free_pct, count);
  endtask

  // Drops valid and waits until every predicted rectangle has been transferred,
  // then gives the block time to finish any walk that produces no result.
  task automatic settle();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_rects.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // The write enable is dropped for a cycle after every write, so back-to-back
  // writes never schedule two values on it in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    apply_reg(idx, val);
  endtask

  function automatic rect_t mk_rect(int unsigned x, int unsigned y, int unsigned w,
                                    int unsigned h);
    rect_t t;
    t.rect_x      = 8'(x);
    t.rect_y      = 8'(y);
    t.rect_width  = 9'(w);
    t.rect_height = 9'(h);
    t.rect_area   = 17'(w * h);
    return t;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row       = '{op: ROW_WRITE, index: idx, data: val, fill: FILL_FREE, typed: 1'b0,
                  want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_frame(fill_e fill, bit typed, rect_t want);
    stim_row_t row;
    row = '{op: ROW_FRAME, index: REG_FRAME_WIDTH, data: '0, fill: fill, typed: typed,
            want: want};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_partial(fill_e fill, logic [CFG_DATA_W-1:0] count);
    stim_row_t row;
    row = '{op: ROW_PARTIAL, index: REG_FRAME_WIDTH, data: count, fill: fill, typed: 1'b0,
            want: '0};
    directed_rows.push_back(row);
  endfunction

  // Random frame sizes: mostly tiny, sometimes up to two dozen, now and then a zero
  // register value that the block must treat as one.
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return CFG_DATA_W'($urandom_range(1, 8));
    if (roll < 96) return CFG_DATA_W'($urandom_range(1, 24));
    return '0;
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int unsigned pct;
    int unsigned k;
    stim_row_t   row;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_FRAME_WIDTH;
    cfg_data_i         = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    mismatch_count     = 0;
    typed_pending      = 1'b0;
    hold_request       = 0;
    burst_left         = 0;
    gaps_on            = 1'b1;
    width_reg          = DIM_RESET;
    height_reg         = DIM_RESET;
    restart_frame();

    // Directed table. Rows with a typed answer are the ones that follow directly
    // from the frame: all free, all blocked, or a single free pixel at the end.
    add_write(REG_FRAME_WIDTH, 9'd1);
    add_write(REG_FRAME_HEIGHT, 9'd1);
    add_frame(FILL_FREE, 1'b1, mk_rect(0, 0, 1, 1));
    add_frame(FILL_BLOCKED, 1'b1, '0);
    // One full-width row: the widest rectangle.
    add_write(REG_FRAME_WIDTH, 9'd256);
    add_frame(FILL_FREE, 1'b1, mk_rect(0, 0, 256, 1));
    // One full-height column: tallest rectangle, then the bottom row alone.
    add_write(REG_FRAME_WIDTH, 9'd1);
    add_write(REG_FRAME_HEIGHT, 9'd256);
    add_frame(FILL_FREE, 1'b1, mk_rect(0, 0, 1, 256));
    add_frame(FILL_LAST_FREE, 1'b1, mk_rect(0, 255, 1, 1));
    // Zero sizes act as one pixel.
    add_write(REG_FRAME_WIDTH, 9'd0);
    add_write(REG_FRAME_HEIGHT, 9'd0);
    add_frame(FILL_FREE, 1'b1, mk_rect(0, 0, 1, 1));
    // An oversized width saturates to the largest frame; only the rightmost pixel
    // is free.
    add_write(REG_FRAME_WIDTH, 9'd511);
    add_frame(FILL_LAST_FREE, 1'b1, mk_rect(255, 0, 1, 1));
    // Writes to undecoded indexes must leave the 4x3 frame alone.
    add_write(REG_FRAME_WIDTH, 9'd4);
    add_write(REG_FRAME_HEIGHT, 9'd3);
    add_write(REG_SPARE_A, 9'd1);
    add_write(REG_SPARE_B, 9'h1FF);
    add_frame(FILL_FREE, 1'b1, mk_rect(0, 0, 4, 3));
    add_frame(FILL_NOISE, 1'b0, '0);
    // A size write in the middle of a frame starts a fresh one.
    add_partial(FILL_FREE, 9'd5);
    add_write(REG_FRAME_WIDTH, 9'd2);
    add_write(REG_FRAME_HEIGHT, 9'd2);
    add_frame(FILL_FREE, 1'b1, mk_rect(0, 0, 2, 2));
    add_frame(FILL_NOISE, 1'b0, '0);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.op)
        ROW_WRITE: begin
          settle();
          write_reg(row.index, row.data);
        end
        ROW_PARTIAL: begin
          send_pixels(row.fill, 50, row.data);
        end
        default: begin
          typed_pending = row.typed;
          typed_rect    = row.want;
          send_frame(row.fill, 50, n);
        end
      endcase
    end

    // Back-pressure: single-pixel frames keep coming while the result side holds
    // off, so the output register fills and the pixel channel has to stall.
    settle();
    write_reg(REG_FRAME_WIDTH, 9'd1);
    write_reg(REG_FRAME_HEIGHT, 9'd1);
    hold_request = LONG_HOLD;
    gaps_on      = 1'b0;
    for (k = 0; k < 40; k++) send_frame(FILL_NOISE, 50, n);
    gaps_on = 1'b1;
    // The sender now waits for every outstanding rectangle before going on.
    settle();

    // Random frames of random size and zero density, with occasional size changes,
    // writes to undecoded indexes, stretches without gaps and a rare full-width row.
    sent = 0;
    while (sent < 200) begin
      if ($urandom_range(0, 99) < 40) begin
        settle();
        if ($urandom_range(0, 99) < 3) begin
          write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(257, 511)));
          write_reg(REG_FRAME_HEIGHT, 9'd1);
        end else begin
          write_reg(REG_FRAME_WIDTH, pick_dim());
          write_reg(REG_FRAME_HEIGHT, pick_dim());
        end
        if ($urandom_range(0, 9) == 0) begin
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                    CFG_DATA_W'($urandom()));
        end
      end
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 30;
        2:       pct = 70;
        3:       pct = 95;
        default: pct = 100;
      endcase
      gaps_on = ($urandom_range(0, 4) != 0);
      send_frame(FILL_NOISE, pct, n);
      sent += n;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb_largest_zero_rectangle_finder: done, clean");
    end else begin
      $display("tb_largest_zero_rectangle_finder: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with the tallest all-free column.
  initial begin : watchdog
    #20_000_000;
    $display("tb_largest_zero_rectangle_finder: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
